>>> design/tcw_pkg.sv
// Package for the text console writer: shared constants, codes and types.
// Used by tcw_ctrl, tcw_datapath and text_console_writer; depends on nothing.
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   localparam int OP_W   = 2;
   localparam int CHAR_W = 8;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int LOC_W  = 11;
   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_LINE_FEED = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_LO  = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_HI  = 8'd127;
   localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'd32;
   localparam int                TAB_STEP       = 8;

   localparam logic [ATTR_W-1:0] COLOUR_RESET = 8'd15;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 2'd0,
      OP_GOTO  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SWEEP_ZERO,
      SWEEP_BLANK,
      SWEEP_SCROLL
   } sweep_mode_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR,
      ST_SCROLL,
      ST_RESP
   } tcw_state_type;

   typedef struct packed {
      logic           capture;
      logic           exec;
      logic           sweep_start;
      logic           sweep_step;
      sweep_mode_type sweep_mode;
      logic           rsp_load;
   } tcw_cmd_type;

   typedef struct packed {
      op_type op;
      logic   scroll_needed;
      logic   sweep_last;
      logic   rsp_free;
   } tcw_status_type;

endpackage

>>> design/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Drives tcw_datapath through tcw_pkg command and status structs.
`timescale 1ns / 1ps

module tcw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  tcw_pkg::tcw_status_type status,
   output tcw_pkg::tcw_cmd_type    cmd
);

   tcw_pkg::tcw_state_type state_ff;
   tcw_pkg::tcw_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_tready      = 1'b0;
      cmd.capture     = 1'b0;
      cmd.exec        = 1'b0;
      cmd.sweep_start = 1'b0;
      cmd.sweep_step  = 1'b0;
      cmd.sweep_mode  = tcw_pkg::SWEEP_ZERO;
      cmd.rsp_load    = 1'b0;
      unique case (state_ff)
         tcw_pkg::ST_INIT: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = tcw_pkg::ST_EXEC;
            end
         end
         tcw_pkg::ST_EXEC: begin
            cmd.exec        = 1'b1;
            cmd.sweep_start = 1'b1;
            if (status.op == tcw_pkg::OP_CLEAR) begin
               state_in = tcw_pkg::ST_CLEAR;
            end else if (status.op == tcw_pkg::OP_WRITE && status.scroll_needed) begin
               state_in = tcw_pkg::ST_SCROLL;
            end else begin
               state_in = tcw_pkg::ST_RESP;
            end
         end
         tcw_pkg::ST_CLEAR: begin
            cmd.sweep_mode = tcw_pkg::SWEEP_BLANK;
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = tcw_pkg::ST_RESP;
            end
         end
         tcw_pkg::ST_SCROLL: begin
            cmd.sweep_mode = tcw_pkg::SWEEP_SCROLL;
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = tcw_pkg::ST_RESP;
            end
         end
         tcw_pkg::ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_INIT;
         end
      endcase
   end

endmodule

>>> design/tcw_datapath.sv
// Datapath of the text console writer: cell memory, cursor, sweep counter,
// colour register and result register. Uses tcw_pkg; commanded by tcw_ctrl.
`timescale 1ns / 1ps

module tcw_datapath #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcw_pkg::tcw_cmd_type              cmd,
   output tcw_pkg::tcw_status_type           status,
   input  logic [tcw_pkg::OP_W-1:0]          req_operation,
   input  logic [tcw_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [tcw_pkg::COL_W-1:0]         req_col,
   input  logic [tcw_pkg::ROW_W-1:0]         req_row,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tcw_pkg::ATTR_W-1:0]        csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tcw_pkg::COL_W-1:0]         rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]         rsp_cursor_row,
   output logic [tcw_pkg::LOC_W-1:0]         rsp_cursor_location,
   output logic [tcw_pkg::CELL_W-1:0]        rsp_cell_value
);

   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int CNT_W   = $clog2(CELLS + 1);
   localparam int WIDE_W  = (ADDR_W > tcw_pkg::LOC_W) ? ADDR_W : tcw_pkg::LOC_W;
   localparam int NCOL_W  = tcw_pkg::COL_W + 1;
   localparam int NROW_W  = tcw_pkg::ROW_W + 1;
   localparam int COPY_N  = CELLS - COLUMNS;

   logic [tcw_pkg::CELL_W-1:0] text_buffer_ff [CELLS];
   logic [tcw_pkg::CELL_W-1:0] rd_data_ff;
   logic                       rd_en;
   logic [ADDR_W-1:0]          rd_addr;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [tcw_pkg::CELL_W-1:0] wr_data;

   logic [tcw_pkg::ATTR_W-1:0] colour_ff;
   logic [tcw_pkg::COL_W-1:0]  cur_col_ff;
   logic [tcw_pkg::COL_W-1:0]  cur_col_in;
   logic [tcw_pkg::ROW_W-1:0]  cur_row_ff;
   logic [tcw_pkg::ROW_W-1:0]  cur_row_in;
   logic [CNT_W-1:0]           cnt_ff;

   tcw_pkg::op_type            op_ff;
   logic [tcw_pkg::CHAR_W-1:0] char_ff;
   logic [tcw_pkg::COL_W-1:0]  col_ff;
   logic [tcw_pkg::ROW_W-1:0]  row_ff;
   logic                       in_range_ff;

   logic                       rsp_valid_ff;
   logic [tcw_pkg::COL_W-1:0]  rsp_col_ff;
   logic [tcw_pkg::ROW_W-1:0]  rsp_row_ff;
   logic [tcw_pkg::LOC_W-1:0]  rsp_loc_ff;
   logic [tcw_pkg::CELL_W-1:0] rsp_cell_ff;

   logic                       req_in_range;
   logic [ADDR_W-1:0]          req_addr;
   logic [ADDR_W-1:0]          cur_addr;
   logic [WIDE_W-1:0]          cur_loc_wide;
   logic [tcw_pkg::CELL_W-1:0] blank;
   logic                       is_print;
   logic                       is_bs;
   logic                       is_tab;
   logic                       is_lf;
   logic                       is_cr;
   logic                       places;
   logic [NCOL_W-1:0]          next_col;
   logic                       wrap;
   logic [NROW_W-1:0]          next_row;
   logic                       scroll;
   logic [CNT_W-1:0]           cnt_prev;
   logic                       sweep_last;

   assign req_in_range = ({1'b0, req_col} < NCOL_W'(COLUMNS)) &&
                         ({1'b0, req_row} < NROW_W'(ROWS));
   assign req_addr = ADDR_W'(ADDR_W'(req_row) * ADDR_W'(COLUMNS) + ADDR_W'(req_col));
   assign cur_addr = ADDR_W'(ADDR_W'(cur_row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_ff));
   assign cur_loc_wide = WIDE_W'(cur_addr);
   assign blank = {colour_ff, tcw_pkg::CHAR_BLANK};

   assign is_print = (char_ff >= tcw_pkg::CHAR_PRINT_LO) && (char_ff <= tcw_pkg::CHAR_PRINT_HI);
   assign is_bs    = (char_ff == tcw_pkg::CHAR_BACKSPACE);
   assign is_tab   = (char_ff == tcw_pkg::CHAR_TAB);
   assign is_lf    = (char_ff == tcw_pkg::CHAR_LINE_FEED);
   assign is_cr    = (char_ff == tcw_pkg::CHAR_RETURN);
   assign places   = is_print || is_tab || is_lf;

   always_comb begin
      if (is_tab) begin
         next_col = {1'b0, cur_col_ff} + NCOL_W'(tcw_pkg::TAB_STEP);
      end else if (is_lf) begin
         next_col = '0;
      end else begin
         next_col = {1'b0, cur_col_ff} + NCOL_W'(1);
      end
   end

   assign wrap     = (next_col >= NCOL_W'(COLUMNS));
   assign next_row = {1'b0, cur_row_ff} + NROW_W'(wrap || is_lf);
   assign scroll   = places && (next_row >= NROW_W'(ROWS));

   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      case (op_ff)
         tcw_pkg::OP_WRITE: begin
            if (places) begin
               cur_col_in = wrap ? '0 : tcw_pkg::COL_W'(next_col);
               cur_row_in = scroll ? tcw_pkg::ROW_W'(ROWS - 1) : tcw_pkg::ROW_W'(next_row);
            end else if (is_bs) begin
               if (cur_col_ff != '0) begin
                  cur_col_in = cur_col_ff - tcw_pkg::COL_W'(1);
               end
            end else if (is_cr) begin
               cur_col_in = '0;
            end
         end
         tcw_pkg::OP_GOTO: begin
            if (in_range_ff) begin
               cur_col_in = col_ff;
               cur_row_in = row_ff;
            end
         end
         tcw_pkg::OP_CLEAR: begin
            cur_col_in = '0;
            cur_row_in = '0;
         end
         default: begin
            cur_col_in = cur_col_ff;
         end
      endcase
   end

   assign cnt_prev = cnt_ff - CNT_W'(1);

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = req_addr;
      wr_en   = 1'b0;
      wr_addr = cur_addr;
      wr_data = {colour_ff, char_ff};
      if (cmd.capture) begin
         rd_en = req_in_range;
      end else if (cmd.exec) begin
         wr_en = (op_ff == tcw_pkg::OP_WRITE) && is_print;
      end else if (cmd.sweep_step) begin
         case (cmd.sweep_mode)
            tcw_pkg::SWEEP_SCROLL: begin
               rd_en   = (cnt_ff < CNT_W'(COPY_N));
               rd_addr = ADDR_W'(cnt_ff + CNT_W'(COLUMNS));
               wr_en   = (cnt_ff != '0);
               wr_addr = ADDR_W'(cnt_prev);
               wr_data = (cnt_prev < CNT_W'(COPY_N)) ? rd_data_ff : blank;
            end
            tcw_pkg::SWEEP_BLANK: begin
               wr_en   = 1'b1;
               wr_addr = ADDR_W'(cnt_ff);
               wr_data = blank;
            end
            default: begin
               wr_en   = 1'b1;
               wr_addr = ADDR_W'(cnt_ff);
               wr_data = '0;
            end
         endcase
      end
   end

   assign sweep_last = (cmd.sweep_mode == tcw_pkg::SWEEP_SCROLL) ?
                       (cnt_ff == CNT_W'(CELLS)) : (cnt_ff == CNT_W'(CELLS - 1));

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= text_buffer_ff[rd_addr];
      end
      if (wr_en) begin
         text_buffer_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_ff    <= tcw_pkg::COLOUR_RESET;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            colour_ff <= csr_wdata;
         end
         if (cmd.exec) begin
            cur_col_ff <= cur_col_in;
            cur_row_ff <= cur_row_in;
         end
         if (cmd.sweep_start) begin
            cnt_ff <= '0;
         end else if (cmd.sweep_step) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= tcw_pkg::op_type'(req_operation);
         char_ff     <= req_char_code;
         col_ff      <= req_col;
         row_ff      <= req_row;
         in_range_ff <= req_in_range;
      end
      if (cmd.rsp_load) begin
         rsp_col_ff  <= cur_col_ff;
         rsp_row_ff  <= cur_row_ff;
         rsp_loc_ff  <= cur_loc_wide[tcw_pkg::LOC_W-1:0];
         rsp_cell_ff <= (op_ff == tcw_pkg::OP_READ && in_range_ff) ? rd_data_ff : '0;
      end
   end

   assign csr_ready            = 1'b1;
   assign status.op            = op_ff;
   assign status.scroll_needed = scroll;
   assign status.sweep_last    = sweep_last;
   assign status.rsp_free      = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid          = rsp_valid_ff;
   assign rsp_cursor_col      = rsp_col_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cursor_location = rsp_loc_ff;
   assign rsp_cell_value      = rsp_cell_ff;

`ifndef ASSERT_OFF
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cur_col_ff} < NCOL_W'(COLUMNS)) && ({1'b0, cur_row_ff} < NROW_W'(ROWS)))
      else $error("Cursor left the screen.");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({1'b0, wr_addr} < (ADDR_W + 1)'(CELLS)))
      else $error("Cell write beyond the buffer.");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("Result register overwritten before the word was taken.");

   a_single_port_use: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.exec, cmd.sweep_step}))
      else $error("Conflicting memory port commands.");
`endif

endmodule

>>> design/text_console_writer.sv
// Character write, goto and read pass from acceptance through EXEC and RESP back to
// IDLE, and no new word is accepted before that; the result is loaded in RESP once
// the output register is free and waits there. A scroll or a clear adds a sweep, set
// by the single write port of the cell memory, which is walked one cell per cycle.
// Reset is synchronous; afterward a clearing pass over ROWS*COLUMNS cells (2000 by
// default) zeroes the memory while req_tready stays low; csr writes are taken out of reset.
`timescale 1ns / 1ps

module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // operation[1:0], char_code[9:2], col[16:10], row[21:17], zero[23:22]
   input  logic [tcw_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // cursor_col[6:0], cursor_row[11:7], cursor_location[22:12], cell_value[38:23],
   // zero[39]
   output logic [tcw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tcw_pkg::ATTR_W-1:0]         csr_wdata
);

   tcw_pkg::tcw_cmd_type       cmd;
   tcw_pkg::tcw_status_type    status;
   logic [tcw_pkg::COL_W-1:0]  cursor_col;
   logic [tcw_pkg::ROW_W-1:0]  cursor_row;
   logic [tcw_pkg::LOC_W-1:0]  cursor_location;
   logic [tcw_pkg::CELL_W-1:0] cell_value;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_tdata[1:0]),
      .req_char_code       (req_tdata[9:2]),
      .req_col             (req_tdata[16:10]),
      .req_row             (req_tdata[21:17]),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_wdata           (csr_wdata),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_cursor_col      (cursor_col),
      .rsp_cursor_row      (cursor_row),
      .rsp_cursor_location (cursor_location),
      .rsp_cell_value      (cell_value)
   );

   assign rsp_tdata = {1'b0, cell_value, cursor_location, cursor_row, cursor_col};

endmodule

>>> bench/console_checker.sv
// console_checker: watches the request, response and colour channels of
// text_console_writer, keeps its own screen, cursor and colour, and compares
// every response word with the oldest prediction. Depends on tcw_pkg.
`timescale 1ns / 1ps

module console_checker #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [tcw_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [tcw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [tcw_pkg::ATTR_W-1:0]     csr_wdata,
   output int                             mismatch_count,
   output int                             reports_due
);

   localparam int CELLS = COLUMNS * ROWS;

   typedef struct packed {
      logic [1:0]                 pad;
      logic [tcw_pkg::ROW_W-1:0]  row;
      logic [tcw_pkg::COL_W-1:0]  col;
      logic [tcw_pkg::CHAR_W-1:0] char_code;
      tcw_pkg::op_type            op;
   } console_cmd_type;

   typedef struct packed {
      logic                       pad;
      logic [tcw_pkg::CELL_W-1:0] cell_value;
      logic [tcw_pkg::LOC_W-1:0]  location;
      logic [tcw_pkg::ROW_W-1:0]  row;
      logic [tcw_pkg::COL_W-1:0]  col;
   } cursor_report_type;

   logic [tcw_pkg::CELL_W-1:0] screen [CELLS];
   logic [tcw_pkg::ATTR_W-1:0] colour;
   int                         pos_col;
   int                         pos_row;
   cursor_report_type          expected_reports [$];

   function automatic logic [tcw_pkg::CELL_W-1:0] blank_cell();
      return {colour, tcw_pkg::CHAR_BLANK};
   endfunction

   task automatic scroll_screen();
      for (int i = 0; i < CELLS - COLUMNS; i++)
         screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++)
         screen[i] = blank_cell();
   endtask

   // Wraps past the right edge and scrolls past the bottom row.
   task automatic move_cursor(input int c, input int r);
      if (c >= COLUMNS) begin
         c = 0;
         r = r + 1;
      end
      if (r >= ROWS) begin
         scroll_screen();
         r = ROWS - 1;
      end
      pos_col = c;
      pos_row = r;
   endtask

   task automatic type_char(input logic [tcw_pkg::CHAR_W-1:0] ch);
      if (ch >= tcw_pkg::CHAR_PRINT_LO && ch <= tcw_pkg::CHAR_PRINT_HI) begin
         screen[pos_row * COLUMNS + pos_col] = {colour, ch};
         move_cursor(pos_col + 1, pos_row);
      end else begin
         case (ch)
            tcw_pkg::CHAR_BACKSPACE: begin
               if (pos_col > 0)
                  pos_col = pos_col - 1;
            end
            tcw_pkg::CHAR_TAB:       move_cursor(pos_col + tcw_pkg::TAB_STEP, pos_row);
            tcw_pkg::CHAR_LINE_FEED: move_cursor(0, pos_row + 1);
            tcw_pkg::CHAR_RETURN:    pos_col = 0;
            default:                 ;
         endcase
      end
   endtask

   task automatic predict_console(input console_cmd_type cmd);
      cursor_report_type rep;
      int                c;
      int                r;
      rep = '0;
      c = int'(cmd.col);
      r = int'(cmd.row);
      case (cmd.op)
         tcw_pkg::OP_WRITE: type_char(cmd.char_code);
         tcw_pkg::OP_GOTO: begin
            if (c < COLUMNS && r < ROWS) begin
               pos_col = c;
               pos_row = r;
            end
         end
         tcw_pkg::OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               screen[i] = blank_cell();
            pos_col = 0;
            pos_row = 0;
         end
         default: begin
            if (c < COLUMNS && r < ROWS)
               rep.cell_value = screen[r * COLUMNS + c];
         end
      endcase
      rep.col      = tcw_pkg::COL_W'(pos_col);
      rep.row      = tcw_pkg::ROW_W'(pos_row);
      rep.location = tcw_pkg::LOC_W'(pos_row * COLUMNS + pos_col);
      expected_reports.push_back(rep);
      reports_due = expected_reports.size();
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   task automatic check_report(input cursor_report_type got);
      cursor_report_type want;
      if (expected_reports.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t ns: response word %h arrived with none expected", $time, got);
      end else begin
         want = expected_reports.pop_front();
         reports_due = expected_reports.size();
         compare_field("cursor_col", int'(want.col), int'(got.col));
         compare_field("cursor_row", int'(want.row), int'(got.row));
         compare_field("cursor_location", int'(want.location), int'(got.location));
         compare_field("cell_value", int'(want.cell_value), int'(got.cell_value));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CELLS; i++)
            screen[i] = '0;
         colour = tcw_pkg::COLOUR_RESET;
         pos_col = 0;
         pos_row = 0;
         expected_reports.delete();
         reports_due = 0;
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready)
            colour = csr_wdata;
         if (req_tvalid && req_tready)
            predict_console(console_cmd_type'(req_tdata));
         if (rsp_tvalid && rsp_tready)
            check_report(cursor_report_type'(rsp_tdata));
      end
   end

endmodule

>>> bench/tb.sv
// tb: drives text_console_writer with directed and random commands, colour
// writes and random stalls on both channels; the verdict comes from the
// mismatch and due counts of console_checker. Needs tcw_pkg, both modules.
`timescale 1ns / 1ps

module tb;

   localparam int COLUMNS = tcw_pkg::COLUMNS_DEFAULT;
   localparam int ROWS    = tcw_pkg::ROWS_DEFAULT;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [tcw_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [tcw_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [tcw_pkg::ATTR_W-1:0]     csr_wdata;
   int                             mismatch_count;
   int                             reports_due;

   bit source_steady;
   bit sink_steady;
   bit sink_hold_req;
   int focus_col;
   int focus_row;

   text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) console_mon (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .reports_due    (reports_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("text_console_writer verification failed");
      $finish;
   end

   task automatic send_command(input tcw_pkg::op_type op,
                               input logic [tcw_pkg::CHAR_W-1:0] ch,
                               input logic [tcw_pkg::COL_W-1:0] col,
                               input logic [tcw_pkg::ROW_W-1:0] row);
      int gap;
      gap = source_steady ? 0 : int'($urandom_range(0, 7));
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {2'b00, row, col, ch, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   // Called right after a word was taken; returns once every response is in.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_colour(input logic [tcw_pkg::ATTR_W-1:0] value);
      wait_idle();
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   task automatic random_command();
      int                         pick;
      int                         sel;
      logic [tcw_pkg::CHAR_W-1:0] ch;
      logic [tcw_pkg::COL_W-1:0]  c;
      logic [tcw_pkg::ROW_W-1:0]  r;
      pick = int'($urandom_range(0, 99));
      ch = tcw_pkg::CHAR_W'($urandom);
      c = tcw_pkg::COL_W'($urandom);
      r = tcw_pkg::ROW_W'($urandom);
      if (pick < 55) begin
         sel = int'($urandom_range(0, 9));
         if (sel < 6)
            ch = tcw_pkg::CHAR_W'($urandom_range(tcw_pkg::CHAR_PRINT_LO,
                                                 tcw_pkg::CHAR_PRINT_HI));
         else if (sel == 6)
            ch = tcw_pkg::CHAR_BACKSPACE;
         else if (sel == 7)
            ch = ($urandom_range(0, 1) != 0) ? tcw_pkg::CHAR_TAB : tcw_pkg::CHAR_RETURN;
         else if (sel == 8)
            ch = tcw_pkg::CHAR_LINE_FEED;
         send_command(tcw_pkg::OP_WRITE, ch, c, r);
      end else if (pick < 72) begin
         sel = int'($urandom_range(0, 9));
         if (sel < 3) begin
            c = tcw_pkg::COL_W'($urandom_range(COLUMNS - 10, COLUMNS - 1));
            r = tcw_pkg::ROW_W'(ROWS - 1);
         end else if (sel < 8) begin
            c = tcw_pkg::COL_W'($urandom_range(0, COLUMNS - 1));
            r = tcw_pkg::ROW_W'($urandom_range(0, ROWS - 1));
         end
         if (c < COLUMNS && r < ROWS) begin
            focus_col = int'(c);
            focus_row = int'(r);
         end
         send_command(tcw_pkg::OP_GOTO, ch, c, r);
      end else if (pick < 74) begin
         send_command(tcw_pkg::OP_CLEAR, ch, c, r);
      end else begin
         sel = int'($urandom_range(0, 3));
         if (sel < 2) begin
            c = tcw_pkg::COL_W'((focus_col + 15 < COLUMNS) ?
                focus_col + int'($urandom_range(0, 15)) :
                int'($urandom_range(focus_col, COLUMNS - 1)));
            r = tcw_pkg::ROW_W'((sel == 1 && focus_row > 0) ? focus_row - 1 : focus_row);
         end else if (sel == 2) begin
            c = tcw_pkg::COL_W'($urandom_range(0, COLUMNS - 1));
            r = tcw_pkg::ROW_W'($urandom_range(0, ROWS - 1));
         end
         send_command(tcw_pkg::OP_READ, ch, c, r);
      end
   endtask

   initial begin : sink_side
      int gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = sink_steady ? 0 : int'($urandom_range(0, 7));
         if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            gap = 400;
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin : stimulus
      logic [tcw_pkg::ATTR_W-1:0] phase_colour;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_wdata  <= '0;
      source_steady = 1'b0;
      sink_steady   = 1'b0;
      sink_hold_req = 1'b0;
      focus_col     = 0;
      focus_row     = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // The screen is zero after reset; colour is still at its reset value.
      send_command(tcw_pkg::OP_READ, 8'd0, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_READ, 8'd0, 7'd127, 5'd31);
      send_command(tcw_pkg::OP_WRITE, 8'd65, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_PRINT_LO, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_PRINT_HI, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_WRITE, 8'd31, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_WRITE, 8'd255, 7'd127, 5'd31);
      send_command(tcw_pkg::OP_WRITE, 8'd0, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_BACKSPACE, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_TAB, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_RETURN, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_BACKSPACE, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_LINE_FEED, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_READ, 8'd0, 7'd0, 5'd0);
      // Writing into the last cell wraps the cursor and scrolls the screen.
      send_command(tcw_pkg::OP_GOTO, 8'd0, tcw_pkg::COL_W'(COLUMNS - 1),
                   tcw_pkg::ROW_W'(ROWS - 1));
      send_command(tcw_pkg::OP_WRITE, 8'd90, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_READ, 8'd0, tcw_pkg::COL_W'(COLUMNS - 1),
                   tcw_pkg::ROW_W'(ROWS - 2));
      send_command(tcw_pkg::OP_READ, 8'd0, 7'd0, tcw_pkg::ROW_W'(ROWS - 1));
      send_command(tcw_pkg::OP_GOTO, 8'd0, tcw_pkg::COL_W'(COLUMNS - 5),
                   tcw_pkg::ROW_W'(ROWS - 1));
      send_command(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_TAB, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_LINE_FEED, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_GOTO, 8'd0, tcw_pkg::COL_W'(COLUMNS), 5'd0);
      send_command(tcw_pkg::OP_GOTO, 8'd0, 7'd0, tcw_pkg::ROW_W'(ROWS));
      send_command(tcw_pkg::OP_CLEAR, 8'd0, 7'd0, 5'd0);
      send_command(tcw_pkg::OP_READ, 8'd0, tcw_pkg::COL_W'(COLUMNS - 1),
                   tcw_pkg::ROW_W'(ROWS - 1));

      for (int p = 0; p < 5; p++) begin
         if (p == 0)
            phase_colour = '0;
         else if (p == 1)
            phase_colour = '1;
         else
            phase_colour = tcw_pkg::ATTR_W'($urandom_range(1, 254));
         write_colour(phase_colour);
         source_steady = (p == 2);
         sink_steady   = (p == 3);
         if (p == 1)
            sink_hold_req = 1'b1;
         repeat (190) random_command();
      end

      wait_idle();
      if (mismatch_count == 0 && reports_due == 0)
         $display("text_console_writer verification clean");
      else
         $display("text_console_writer verification failed");
      $finish;
   end

endmodule

>>> files.f
design/tcw_pkg.sv
design/tcw_ctrl.sv
design/tcw_datapath.sv
design/text_console_writer.sv
bench/console_checker.sv
bench/tb.sv
